// ----- src/quaternion_pd_attitude_torque_core_assert.svh -----
// Assertion macros shared by the attitude torque core.
// Every property is sampled on the rising edge of clock and is off during reset.
`ifndef QUATERNION_PD_ATTITUDE_TORQUE_CORE_ASSERT_SVH
`define QUATERNION_PD_ATTITUDE_TORQUE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QPAT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QPAT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/qpat_pkg.sv -----
package qpat_pkg;

   localparam int CANON_WIDTH     = 16;
   localparam int GAIN_WIDTH      = 24;
   localparam int PROD_WIDTH      = 2 * CANON_WIDTH;
   localparam int ERR_WIDTH       = PROD_WIDTH + 2;
   localparam int RATE_PROD_WIDTH = GAIN_WIDTH + CANON_WIDTH;
   localparam int PROP_PROD_WIDTH = GAIN_WIDTH + ERR_WIDTH;
   localparam int ACC_WIDTH       = PROP_PROD_WIDTH + 1;
   localparam int OUT_WIDTH       = 32;
   localparam int OUT_SHIFT       = 24;
   localparam int RATE_ALIGN      = 16;

   localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS = ACC_WIDTH'(1) << (OUT_SHIFT - 1);
   localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH - 1){1'b1}}};
   localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH - 1){1'b0}}};

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROP_GAIN = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RATE_GAIN = 2'd1;

   typedef struct packed {
      logic signed [PROD_WIDTH-1:0] a;
      logic signed [PROD_WIDTH-1:0] b;
      logic signed [PROD_WIDTH-1:0] c;
      logic signed [PROD_WIDTH-1:0] d;
   } term_quad_type;

   typedef struct packed {
      term_quad_type                     ex;
      term_quad_type                     ey;
      term_quad_type                     ez;
      term_quad_type                     ew;
      logic signed [RATE_PROD_WIDTH-1:0] dx;
      logic signed [RATE_PROD_WIDTH-1:0] dy;
      logic signed [RATE_PROD_WIDTH-1:0] dz;
   } prod_stage_type;

   typedef struct packed {
      logic signed [ERR_WIDTH-1:0]       ex;
      logic signed [ERR_WIDTH-1:0]       ey;
      logic signed [ERR_WIDTH-1:0]       ez;
      logic                              flip;
      logic signed [RATE_PROD_WIDTH-1:0] dx;
      logic signed [RATE_PROD_WIDTH-1:0] dy;
      logic signed [RATE_PROD_WIDTH-1:0] dz;
   } err_stage_type;

   typedef struct packed {
      logic signed [PROP_PROD_WIDTH-1:0] px;
      logic signed [PROP_PROD_WIDTH-1:0] py;
      logic signed [PROP_PROD_WIDTH-1:0] pz;
      logic                              flip;
      logic signed [RATE_PROD_WIDTH-1:0] dx;
      logic signed [RATE_PROD_WIDTH-1:0] dy;
      logic signed [RATE_PROD_WIDTH-1:0] dz;
   } gain_stage_type;

   typedef struct packed {
      logic signed [ACC_WIDTH-1:0] x;
      logic signed [ACC_WIDTH-1:0] y;
      logic signed [ACC_WIDTH-1:0] z;
   } acc_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] x;
      logic signed [OUT_WIDTH-1:0] y;
      logic signed [OUT_WIDTH-1:0] z;
   } torque_type;

endpackage

// ----- src/qpat_product_stage.sv -----
module qpat_product_stage #(
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic                                   in_valid,
   input  logic signed [COMPONENT_WIDTH-1:0]      target_x,
   input  logic signed [COMPONENT_WIDTH-1:0]      target_y,
   input  logic signed [COMPONENT_WIDTH-1:0]      target_z,
   input  logic signed [COMPONENT_WIDTH-1:0]      target_w,
   input  logic signed [COMPONENT_WIDTH-1:0]      meas_x,
   input  logic signed [COMPONENT_WIDTH-1:0]      meas_y,
   input  logic signed [COMPONENT_WIDTH-1:0]      meas_z,
   input  logic signed [COMPONENT_WIDTH-1:0]      meas_w,
   input  logic signed [COMPONENT_WIDTH-1:0]      rate_x,
   input  logic signed [COMPONENT_WIDTH-1:0]      rate_y,
   input  logic signed [COMPONENT_WIDTH-1:0]      rate_z,
   input  logic signed [qpat_pkg::GAIN_WIDTH-1:0] rate_gain,
   output logic                                   out_valid,
   output qpat_pkg::prod_stage_type               out_data
);
   import qpat_pkg::*;

   localparam int UP_SHIFT   = (COMPONENT_WIDTH < CANON_WIDTH) ?
                               CANON_WIDTH - COMPONENT_WIDTH : 0;
   localparam int DOWN_SHIFT = (COMPONENT_WIDTH > CANON_WIDTH) ?
                               COMPONENT_WIDTH - CANON_WIDTH : 0;
   localparam int EXT_WIDTH  = COMPONENT_WIDTH + UP_SHIFT;

   // Wider components are floor-shifted down, narrower ones are scaled up.
   function automatic logic signed [CANON_WIDTH-1:0] canon(
      input logic signed [COMPONENT_WIDTH-1:0] raw
   );
      logic signed [EXT_WIDTH-1:0] ext;
      ext = EXT_WIDTH'(raw);
      ext = (ext <<< UP_SHIFT) >>> DOWN_SHIFT;
      return $signed(ext[CANON_WIDTH-1:0]);
   endfunction

   logic signed [CANON_WIDTH-1:0] tx, ty, tz, tw, mx, my, mz, mw, rx, ry, rz;
   logic           valid_ff;
   prod_stage_type data_in, data_ff;

   assign tx = canon(target_x);
   assign ty = canon(target_y);
   assign tz = canon(target_z);
   assign tw = canon(target_w);
   assign mx = canon(meas_x);
   assign my = canon(meas_y);
   assign mz = canon(meas_z);
   assign mw = canon(meas_w);
   assign rx = canon(rate_x);
   assign ry = canon(rate_y);
   assign rz = canon(rate_z);

   always_comb begin
      data_in.ex.a = PROD_WIDTH'(tw) * PROD_WIDTH'(mx);
      data_in.ex.b = PROD_WIDTH'(mw) * PROD_WIDTH'(tx);
      data_in.ex.c = PROD_WIDTH'(ty) * PROD_WIDTH'(mz);
      data_in.ex.d = PROD_WIDTH'(tz) * PROD_WIDTH'(my);
      data_in.ey.a = PROD_WIDTH'(tw) * PROD_WIDTH'(my);
      data_in.ey.b = PROD_WIDTH'(mw) * PROD_WIDTH'(ty);
      data_in.ey.c = PROD_WIDTH'(tz) * PROD_WIDTH'(mx);
      data_in.ey.d = PROD_WIDTH'(tx) * PROD_WIDTH'(mz);
      data_in.ez.a = PROD_WIDTH'(tw) * PROD_WIDTH'(mz);
      data_in.ez.b = PROD_WIDTH'(mw) * PROD_WIDTH'(tz);
      data_in.ez.c = PROD_WIDTH'(tx) * PROD_WIDTH'(my);
      data_in.ez.d = PROD_WIDTH'(ty) * PROD_WIDTH'(mx);
      data_in.ew.a = PROD_WIDTH'(tw) * PROD_WIDTH'(mw);
      data_in.ew.b = PROD_WIDTH'(tx) * PROD_WIDTH'(mx);
      data_in.ew.c = PROD_WIDTH'(ty) * PROD_WIDTH'(my);
      data_in.ew.d = PROD_WIDTH'(tz) * PROD_WIDTH'(mz);
      data_in.dx   = RATE_PROD_WIDTH'(rate_gain) * RATE_PROD_WIDTH'(rx);
      data_in.dy   = RATE_PROD_WIDTH'(rate_gain) * RATE_PROD_WIDTH'(ry);
      data_in.dz   = RATE_PROD_WIDTH'(rate_gain) * RATE_PROD_WIDTH'(rz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- src/qpat_error_stage.sv -----
module qpat_error_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  qpat_pkg::prod_stage_type in_data,
   output logic                     out_valid,
   output qpat_pkg::err_stage_type  out_data
);
   import qpat_pkg::*;

   logic signed [ERR_WIDTH-1:0] ew;
   logic          valid_ff;
   err_stage_type data_in, data_ff;

   always_comb begin
      data_in.ex = ERR_WIDTH'(in_data.ex.a) - ERR_WIDTH'(in_data.ex.b)
                 - ERR_WIDTH'(in_data.ex.c) + ERR_WIDTH'(in_data.ex.d);
      data_in.ey = ERR_WIDTH'(in_data.ey.a) - ERR_WIDTH'(in_data.ey.b)
                 - ERR_WIDTH'(in_data.ey.c) + ERR_WIDTH'(in_data.ey.d);
      data_in.ez = ERR_WIDTH'(in_data.ez.a) - ERR_WIDTH'(in_data.ez.b)
                 - ERR_WIDTH'(in_data.ez.c) + ERR_WIDTH'(in_data.ez.d);
      ew         = ERR_WIDTH'(in_data.ew.a) + ERR_WIDTH'(in_data.ew.b)
                 + ERR_WIDTH'(in_data.ew.c) + ERR_WIDTH'(in_data.ew.d);
      // A negative scalar part selects the shorter rotation.
      data_in.flip = ew[ERR_WIDTH-1];
      data_in.dx   = in_data.dx;
      data_in.dy   = in_data.dy;
      data_in.dz   = in_data.dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- src/qpat_gain_stage.sv -----
module qpat_gain_stage (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic                                   in_valid,
   input  qpat_pkg::err_stage_type                in_data,
   input  logic signed [qpat_pkg::GAIN_WIDTH-1:0] prop_gain,
   output logic                                   out_valid,
   output qpat_pkg::gain_stage_type               out_data
);
   import qpat_pkg::*;

   logic           valid_ff;
   gain_stage_type data_in, data_ff;

   always_comb begin
      data_in.px   = PROP_PROD_WIDTH'(prop_gain) * PROP_PROD_WIDTH'(in_data.ex);
      data_in.py   = PROP_PROD_WIDTH'(prop_gain) * PROP_PROD_WIDTH'(in_data.ey);
      data_in.pz   = PROP_PROD_WIDTH'(prop_gain) * PROP_PROD_WIDTH'(in_data.ez);
      data_in.flip = in_data.flip;
      data_in.dx   = in_data.dx;
      data_in.dy   = in_data.dy;
      data_in.dz   = in_data.dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- src/qpat_output_stage.sv -----
module qpat_output_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  qpat_pkg::gain_stage_type  in_data,
   output logic                      out_valid,
   output qpat_pkg::torque_type      out_data
);
   import qpat_pkg::*;

   localparam int Q_WIDTH = ACC_WIDTH - OUT_SHIFT;

   // The rounding bias is already in the sum, so a floor shift finishes the rounding.
   function automatic logic signed [OUT_WIDTH-1:0] round_sat(
      input logic signed [ACC_WIDTH-1:0] acc
   );
      logic [Q_WIDTH-1:0] q;
      logic [Q_WIDTH-OUT_WIDTH:0] top;
      q   = acc[ACC_WIDTH-1:OUT_SHIFT];
      top = q[Q_WIDTH-1:OUT_WIDTH-1];
      if ((&top) || !(|top)) begin
         return $signed(q[OUT_WIDTH-1:0]);
      end else if (q[Q_WIDTH-1]) begin
         return OUT_MIN;
      end else begin
         return OUT_MAX;
      end
   endfunction

   function automatic logic signed [ACC_WIDTH-1:0] axis_sum(
      input logic                              flip,
      input logic signed [PROP_PROD_WIDTH-1:0] prop,
      input logic signed [RATE_PROD_WIDTH-1:0] damp
   );
      logic signed [ACC_WIDTH-1:0] p_ext;
      logic signed [ACC_WIDTH-1:0] d_ext;
      p_ext = ACC_WIDTH'(prop);
      d_ext = ACC_WIDTH'(damp) <<< RATE_ALIGN;
      return (flip ? -p_ext : p_ext) + d_ext + ROUND_BIAS;
   endfunction

   logic       acc_valid_ff, out_valid_ff;
   acc_type    acc_in, acc_ff;
   torque_type torque_in, torque_ff;

   always_comb begin
      acc_in.x    = axis_sum(in_data.flip, in_data.px, in_data.dx);
      acc_in.y    = axis_sum(in_data.flip, in_data.py, in_data.dy);
      acc_in.z    = axis_sum(in_data.flip, in_data.pz, in_data.dz);
      torque_in.x = round_sat(acc_ff.x);
      torque_in.y = round_sat(acc_ff.y);
      torque_in.z = round_sat(acc_ff.z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         acc_valid_ff <= in_valid;
         out_valid_ff <= acc_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_ff    <= acc_in;
         torque_ff <= torque_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = torque_ff;

endmodule

// ----- src/quaternion_pd_attitude_torque_core.sv -----
// A transferred request passes the product, error, gain, accumulator and torque registers, in order, to rsp_valid.
// Throughput: one item per cycle; the five register stages advance together,
// and the whole pipeline holds while a result waits on rsp_ready.
// Reset: synchronous and active high; it empties the pipeline and clears both gains.
`include "quaternion_pd_attitude_torque_core_assert.svh"

module quaternion_pd_attitude_torque_core #(
   parameter int COMPONENT_WIDTH = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic signed [COMPONENT_WIDTH-1:0]           req_target_x,
   input  logic signed [COMPONENT_WIDTH-1:0]           req_target_y,
   input  logic signed [COMPONENT_WIDTH-1:0]           req_target_z,
   input  logic signed [COMPONENT_WIDTH-1:0]           req_target_w,
   input  logic signed [COMPONENT_WIDTH-1:0]           req_meas_x,
   input  logic signed [COMPONENT_WIDTH-1:0]           req_meas_y,
   input  logic signed [COMPONENT_WIDTH-1:0]           req_meas_z,
   input  logic signed [COMPONENT_WIDTH-1:0]           req_meas_w,
   input  logic signed [COMPONENT_WIDTH-1:0]           req_rate_x,
   input  logic signed [COMPONENT_WIDTH-1:0]           req_rate_y,
   input  logic signed [COMPONENT_WIDTH-1:0]           req_rate_z,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [qpat_pkg::OUT_WIDTH-1:0]       rsp_torque_x,
   output logic signed [qpat_pkg::OUT_WIDTH-1:0]       rsp_torque_y,
   output logic signed [qpat_pkg::OUT_WIDTH-1:0]       rsp_torque_z,
   input  logic                                        csr_write_enable,
   input  logic [qpat_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [qpat_pkg::GAIN_WIDTH-1:0]             csr_write_data
);
   import qpat_pkg::*;

   logic signed [GAIN_WIDTH-1:0] prop_gain_ff, prop_gain_in;
   logic signed [GAIN_WIDTH-1:0] rate_gain_ff, rate_gain_in;

   logic           advance;
   logic           prod_valid, err_valid, gain_valid, out_valid;
   prod_stage_type prod_data;
   err_stage_type  err_data;
   gain_stage_type gain_data;
   torque_type     torque;

   always_comb begin
      prop_gain_in = prop_gain_ff;
      rate_gain_in = rate_gain_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PROP_GAIN: prop_gain_in = $signed(csr_write_data);
            CSR_RATE_GAIN: rate_gain_in = $signed(csr_write_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff <= '0;
         rate_gain_ff <= '0;
      end else begin
         prop_gain_ff <= prop_gain_in;
         rate_gain_ff <= rate_gain_in;
      end
   end

   assign advance   = !out_valid || rsp_ready;
   assign req_ready = advance;

   qpat_product_stage #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH)
   ) u_product (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .target_x  (req_target_x),
      .target_y  (req_target_y),
      .target_z  (req_target_z),
      .target_w  (req_target_w),
      .meas_x    (req_meas_x),
      .meas_y    (req_meas_y),
      .meas_z    (req_meas_z),
      .meas_w    (req_meas_w),
      .rate_x    (req_rate_x),
      .rate_y    (req_rate_y),
      .rate_z    (req_rate_z),
      .rate_gain (rate_gain_ff),
      .out_valid (prod_valid),
      .out_data  (prod_data)
   );

   qpat_error_stage u_error (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (prod_valid),
      .in_data   (prod_data),
      .out_valid (err_valid),
      .out_data  (err_data)
   );

   qpat_gain_stage u_gain (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (err_valid),
      .in_data   (err_data),
      .prop_gain (prop_gain_ff),
      .out_valid (gain_valid),
      .out_data  (gain_data)
   );

   qpat_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (gain_valid),
      .in_data   (gain_data),
      .out_valid (out_valid),
      .out_data  (torque)
   );

   assign rsp_valid    = out_valid;
   assign rsp_torque_x = torque.x;
   assign rsp_torque_y = torque.y;
   assign rsp_torque_z = torque.z;

   `QPAT_ASSERT_NEXT(a_transfer_enters, req_valid && req_ready, prod_valid, "accepted item lost at entry")
   `QPAT_ASSERT_NEXT(a_stall_holds, !advance, {prod_valid, err_valid, gain_valid} == $past({prod_valid, err_valid, gain_valid}), "pipeline moved during stall")
   `QPAT_ASSERT_NEXT(a_prop_gain_write, csr_write_enable && (csr_index == CSR_PROP_GAIN), prop_gain_ff == $past($signed(csr_write_data)), "proportional gain write lost")
   `QPAT_ASSERT_SAME(a_ready_when_empty, !rsp_valid, req_ready, "input stalled with empty output")

endmodule
